>>> design/mohs_pkg.sv
// types, constants and weight tables of the 1-10-1 sigmoid network
// no dependencies; imported by mohs_unit and mlp_one_hidden_sigmoid_inference
`timescale 1ns / 1ps
`default_nettype none

package mohs_pkg;

  // field and datapath widths
  localparam int X_W    = 16;  // input and output samples, Q4.12
  localparam int W0_W   = 17;  // hidden weights, Q.12
  localparam int B0_W   = 17;  // hidden biases, Q.12
  localparam int W1_W   = 14;  // output weights, Q.12
  localparam int B1_W   = 14;  // output bias, Q.12
  localparam int V_W    = 34;  // pre-activation, Q.24
  localparam int SIG_W  = 13;  // sigmoid value, unsigned Q.12 in [0, 4096]
  localparam int PROD_W = 28;  // sigmoid times output weight, Q.24
  localparam int MAX_UNITS = 64;

  // sigmoid saturation limit: 8.0 in Q.24
  localparam logic signed [V_W-1:0] SIG_LIM = V_W'(64'sd1 <<< 27);
  localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(4096);

  localparam logic signed [W0_W-1:0] W0_TAB [MAX_UNITS] = '{
    0: 17'sd174,    1: -17'sd27143, 2: -17'sd43247, 3: -17'sd19494,
    4: -17'sd10286, 5: -17'sd243,   6: 17'sd2907,   7: 17'sd4385,
    8: 17'sd740,    9: -17'sd10098, default: 17'sd0
  };

  localparam logic signed [B0_W-1:0] B0_TAB [MAX_UNITS] = '{
    0: 17'sd8112,   1: 17'sd27084,  2: 17'sd51960,  3: 17'sd14108,
    4: -17'sd7538,  5: -17'sd673,   6: 17'sd1989,   7: 17'sd8664,
    8: 17'sd1034,   9: 17'sd24229,  default: 17'sd0
  };

  localparam logic signed [W1_W-1:0] W1_TAB [MAX_UNITS] = '{
    0: -14'sd715,   1: 14'sd459,    2: 14'sd1081,   3: 14'sd104,
    4: 14'sd393,    5: 14'sd1705,   6: 14'sd2146,   7: 14'sd1420,
    8: -14'sd586,   9: -14'sd4051,  default: 14'sd0
  };

  localparam logic signed [B1_W-1:0] B1 = -14'sd74;

  // exp(-2^(k-12)) in Q.30
  localparam longint unsigned EXPQ [15] = '{
    64'd1073479712, 64'd1073217664, 64'd1072693760, 64'd1071646719,
    64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
    64'd1008687096, 64'd947573834,  64'd836230973,  64'd651257337,
    64'd395007542,  64'd145315154,  64'd19666268
  };

  // per-stage advance enables handed to each hidden unit
  typedef struct packed {
    logic mul;  // pre-activation stage
    logic lut;  // sigmoid table stage
    logic prd;  // output weight stage
  } pipe_en_t;

  // exp(-a/4096) in Q.30, product of one factor per set bit of a
  function automatic longint unsigned exp_neg_q30(input logic [14:0] a);
    longint unsigned r;
    r = 64'd1 << 30;
    for (int k = 0; k < 15; k++) begin
      if (a[k]) begin
        r = (r * EXPQ[k] + (64'd1 << 29)) >> 30;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/mohs_unit.sv
// one hidden unit: multiply-add, sigmoid table lookup, output weighting
// depends on mohs_pkg; the table contents are worked out at elaboration
`timescale 1ns / 1ps
`default_nettype none

module mohs_unit #(
  parameter int UNIT_IDX = 0,
  parameter int SIG_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire mohs_pkg::pipe_en_t                   en,
  input  wire logic signed [mohs_pkg::X_W-1:0]      in_x,
  output logic signed [mohs_pkg::PROD_W-1:0]        prod_o
);

  import mohs_pkg::*;

  localparam int TABLE_N = 1 << SIG_BITS;
  localparam int STEP    = 65536 >> SIG_BITS;

  // sigmoid at the midpoint of each cell of [-8, 8)
  logic [SIG_W-1:0] rom [TABLE_N];

  for (genvar ge = 0; ge < TABLE_N; ge++) begin : g_rom
    localparam int MID  = -32768 + ge * STEP + STEP / 2;
    localparam int ABSM = (MID < 0) ? -MID : MID;
    localparam longint unsigned EXPV = exp_neg_q30(15'(ABSM));
    localparam longint unsigned DEN  = (64'd1 << 30) + EXPV;
    localparam longint unsigned PQ   = ((64'd1 << 42) + DEN / 2) / DEN;
    localparam logic [SIG_W-1:0] ENTRY =
      (MID < 0) ? SIG_W'(64'd4096 - PQ) : SIG_W'(PQ);
    assign rom[ge] = ENTRY;
  end

  // stage 1: pre-activation in Q.24
  logic signed [X_W+W0_W-1:0] mul;
  logic signed [V_W-1:0]      v_nxt;
  logic signed [V_W-1:0]      v_r;

  always_comb begin
    mul   = in_x * W0_TAB[UNIT_IDX];
    v_nxt = V_W'(mul) + (V_W'(B0_TAB[UNIT_IDX]) <<< 12);
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      v_r <= v_nxt;
    end
  end

  // stage 2: saturation flags and table read
  logic                 sat_lo;
  logic                 sat_hi;
  logic [SIG_BITS-1:0]  lut_idx;
  logic                 sat_lo_r;
  logic                 sat_hi_r;
  logic [SIG_W-1:0]     lut_q_r;

  always_comb begin
    sat_lo  = v_r < -SIG_LIM;
    sat_hi  = v_r >= SIG_LIM;
    // (v + 8.0) >> (28 - SIG_BITS): bias flips the top bit in range
    lut_idx = {~v_r[27], v_r[26 -: SIG_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (en.lut) begin
      sat_lo_r <= sat_lo;
      sat_hi_r <= sat_hi;
      lut_q_r  <= rom[lut_idx];
    end
  end

  // stage 3: weighted sigmoid
  logic [SIG_W-1:0]           sig;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;

  always_comb begin
    if (sat_lo_r) begin
      sig = '0;
    end else if (sat_hi_r) begin
      sig = SIG_ONE;
    end else begin
      sig = lut_q_r;
    end
    prod_nxt = $signed({1'b0, sig}) * W1_TAB[UNIT_IDX];
  end

  always_ff @(posedge clk) begin
    if (en.prd) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

>>> design/mlp_one_hidden_sigmoid_inference.sv
// top level of the fixed-weight 1-N-1 sigmoid network, Q4.12 in and out
// depends on mohs_pkg and mohs_unit
`timescale 1ns / 1ps
`default_nettype none

// One signed Q4.12 sample x enters per transaction and one signed Q4.12 result y
// leaves per transaction, in order. Every hidden unit has its own multiplier, its
// own copy of the sigmoid table (2^SIGMOID_TABLE_BITS words of 13 bits, read
// through a registered port) and its own output-weight multiplier, so a new
// sample is taken in every cycle unless a stalled output fills the pipeline.
// The stages are pre-activation, table read, weighting, L four-input adder
// levels over the hidden units (L = 2 for ten units), then bias, round half up
// and clamp into the output register. Each stage advances when the stage after
// it is empty or advancing, so bubbles close up and a new sample can enter
// while a finished result is still held on the output.

module mlp_one_hidden_sigmoid_inference #(
  parameter int HIDDEN_UNITS       = 10,
  parameter int SIGMOID_TABLE_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [mohs_pkg::X_W-1:0]  in_x,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [mohs_pkg::X_W-1:0]       out_y
);

  import mohs_pkg::*;

  // adder tree shape: four inputs per node, padded with zeros
  localparam int TREE_LVLS = (HIDDEN_UNITS <= 1) ? 1 : ($clog2(HIDDEN_UNITS) + 1) / 2;
  localparam int PAD       = 1 << (2 * TREE_LVLS);
  localparam int QUADS     = PAD / 4;
  localparam int ACC_W     = PROD_W + $clog2(HIDDEN_UNITS) + 2;
  localparam int YQ_W      = ACC_W - 12;
  // stage numbering: 0 pre-activation, 1 table, 2 weighting, tree, output
  localparam int TREE_ST   = 3;
  localparam int NST       = TREE_LVLS + 4;

  localparam logic signed [YQ_W-1:0] Y_MAX = YQ_W'(32767);
  localparam logic signed [YQ_W-1:0] Y_MIN = -YQ_W'(32768);

  // valid bits and stage enables
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];

  // hidden units
  pipe_en_t unit_en;
  wire signed [PROD_W-1:0] prod_w [HIDDEN_UNITS];

  assign unit_en = '{mul: en[0], lut: en[1], prd: en[2]};

  for (genvar gu = 0; gu < HIDDEN_UNITS; gu++) begin : g_unit
    mohs_unit #(
      .UNIT_IDX (gu),
      .SIG_BITS (SIGMOID_TABLE_BITS)
    ) u_unit (
      .clk    (clk),
      .en     (unit_en),
      .in_x   (in_x),
      .prod_o (prod_w[gu])
    );
  end

  // registered four-input adder tree over the weighted sigmoids
  logic signed [ACC_W-1:0] tin    [TREE_LVLS][PAD];
  logic signed [ACC_W-1:0] tree_r [TREE_LVLS][QUADS];

  always_comb begin
    for (int k = 0; k < HIDDEN_UNITS; k++) begin
      tin[0][k] = ACC_W'(prod_w[k]);
    end
    for (int k = HIDDEN_UNITS; k < PAD; k++) begin
      tin[0][k] = '0;
    end
    for (int l = 1; l < TREE_LVLS; l++) begin
      for (int k = 0; k < QUADS; k++) begin
        tin[l][k] = tree_r[l-1][k];
      end
      for (int k = QUADS; k < PAD; k++) begin
        tin[l][k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < TREE_LVLS; l++) begin
      if (en[TREE_ST+l]) begin
        for (int n = 0; n < QUADS; n++) begin
          tree_r[l][n] <= tin[l][4*n] + tin[l][4*n+1] + tin[l][4*n+2] + tin[l][4*n+3];
        end
      end
    end
  end

  // output bias, round half toward plus infinity, clamp to Q4.12
  logic signed [ACC_W-1:0] fin;
  logic signed [YQ_W-1:0]  yq;
  logic signed [X_W-1:0]   y_nxt;
  logic signed [X_W-1:0]   out_y_r;

  always_comb begin
    fin = tree_r[TREE_LVLS-1][0] + (ACC_W'(B1) <<< 12) + ACC_W'(2048);
    yq  = YQ_W'(fin >>> 12);
    if (yq > Y_MAX) begin
      y_nxt = X_W'(Y_MAX);
    end else if (yq < Y_MIN) begin
      y_nxt = X_W'(Y_MIN);
    end else begin
      y_nxt = X_W'(yq);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_y_r <= y_nxt;
    end
  end

  assign out_y = out_y_r;

endmodule

`default_nettype wire
